[rtl/teq_pkg.sv]
package teq_pkg;

    localparam int QUEUE_DEPTH_DEF = 32;
    localparam int NUM_KINDS_DEF   = 16;
    localparam int MAX_POP         = 32;
    localparam int CNT_W           = 6;
    localparam int COUNT_MAX       = 63;

    typedef enum logic [2:0] {
        CMD_DELAY  = 3'd0,
        CMD_ABS    = 3'd1,
        CMD_TICK   = 3'd2,
        CMD_QCOUNT = 3'd3,
        CMD_QAGE   = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        OP_SCHED,
        OP_TICK,
        OP_QCOUNT,
        OP_QAGE
    } t_op;

    typedef enum logic [1:0] {
        RK_FIRED = 2'd0,
        RK_ACK   = 2'd1,
        RK_COUNT = 2'd2,
        RK_AGE   = 2'd3
    } t_rkind;

    typedef enum logic {
        ST_IDLE,
        ST_TICK
    } t_state;

    typedef struct packed {
        t_op         op;
        logic [3:0]  kind;
        logic [31:0] due;
        logic [31:0] now;
        logic [15:0] tag;
    } t_req;

endpackage

[rtl/teq_front.sv]
module teq_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [2:0]        i_cmd,
    input  logic [3:0]        i_event_kind,
    input  logic [31:0]       i_time_value,
    input  logic [31:0]       i_now_time,
    input  logic [15:0]       i_label_tag,
    output teq_pkg::t_req     o_req,
    output logic              o_req_valid,
    input  logic              i_req_pop
);

    teq_pkg::t_req r_ent [2];
    logic          r_wr;
    logic          r_rd;
    logic [1:0]    r_cnt;

    logic          accept;
    logic          push;
    logic          pop;
    logic [32:0]   sum;
    teq_pkg::t_req req;

    assign o_in_stall  = (r_cnt == 2'd2);
    assign accept      = i_in_valid && !o_in_stall;
    assign o_req_valid = (r_cnt != 2'd0);
    assign o_req       = r_ent[r_rd];
    assign pop         = i_req_pop && o_req_valid;

    always_comb begin
        sum      = {1'b0, i_now_time} + {1'b0, i_time_value};
        req.kind = i_event_kind;
        req.now  = i_now_time;
        req.tag  = i_label_tag;
        req.due  = i_time_value;
        req.op   = teq_pkg::OP_SCHED;
        push     = accept;
        case (i_cmd)
            teq_pkg::CMD_DELAY: begin
                // saturate the delayed due time
                req.due = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
            end
            teq_pkg::CMD_ABS:    req.op = teq_pkg::OP_SCHED;
            teq_pkg::CMD_TICK:   req.op = teq_pkg::OP_TICK;
            teq_pkg::CMD_QCOUNT: req.op = teq_pkg::OP_QCOUNT;
            teq_pkg::CMD_QAGE:   req.op = teq_pkg::OP_QAGE;
            default:             push = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wr <= !r_wr;
            end
            if (pop) begin
                r_rd <= !r_rd;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_ent[r_wr] <= req;
        end
    end

endmodule

[rtl/teq_back.sv]
module teq_back #(
    parameter int QUEUE_DEPTH = teq_pkg::QUEUE_DEPTH_DEF,
    parameter int NUM_KINDS   = teq_pkg::NUM_KINDS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  teq_pkg::t_req i_req,
    input  logic          i_req_valid,
    output logic          o_req_pop,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output logic [1:0]    o_reply_kind,
    output logic [3:0]    o_out_kind,
    output logic [15:0]   o_out_tag,
    output logic [31:0]   o_reply_value,
    output logic          o_ok_flag,
    output logic          o_last_flag
);

    localparam int FW = $clog2(QUEUE_DEPTH + 1);
    localparam int KW = $clog2(NUM_KINDS);
    localparam int EW = (KW > 4) ? KW : 4;
    localparam int PW = $clog2(teq_pkg::MAX_POP);

    logic [31:0]             r_due  [QUEUE_DEPTH];
    logic [3:0]              r_kind [QUEUE_DEPTH];
    logic [15:0]             r_tag  [QUEUE_DEPTH];
    logic [FW-1:0]           r_fill;
    logic [teq_pkg::CNT_W-1:0] r_count [NUM_KINDS];
    logic [31:0]             r_last [NUM_KINDS];
    logic [NUM_KINDS-1:0]    r_mark;
    logic [PW-1:0]           r_npop;

    teq_pkg::t_state r_state, n_state;

    logic               r_out_valid;
    logic [1:0]         r_rk;
    logic [3:0]         r_okind;
    logic [15:0]        r_otag;
    logic [31:0]        r_oval;
    logic               r_ok;
    logic               r_olast;

    logic [1:0]         n_rk;
    logic [3:0]         n_okind;
    logic [15:0]        n_otag;
    logic [31:0]        n_oval;
    logic               n_ok;
    logic               n_olast;

    logic               out_free;
    logic               emit;
    logic               do_ins;
    logic               do_pop;
    logic               full;
    logic               due_now;
    logic [QUEUE_DEPTH-1:0] gt;
    logic [EW:0]        kx;
    logic               k_in;
    logic [KW-1:0]      kidx;
    logic [EW:0]        fx;
    logic               f_in;
    logic [KW-1:0]      fidx;

    assign out_free = !r_out_valid || !i_out_stall;
    assign full     = (r_fill >= FW'(QUEUE_DEPTH));
    assign due_now  = (r_fill != '0) && (r_due[0] <= i_req.now);
    assign kx       = (EW + 1)'(i_req.kind);
    assign k_in     = kx < (EW + 1)'(NUM_KINDS);
    assign kidx     = kx[KW-1:0];
    assign fx       = (EW + 1)'(r_kind[0]);
    assign f_in     = fx < (EW + 1)'(NUM_KINDS);
    assign fidx     = fx[KW-1:0];

    // sorted queue: each cell knows whether it holds a later due time
    always_comb begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            gt[i] = (FW'(i) < r_fill) && (r_due[i] > i_req.due);
        end
    end

    always_comb begin
        n_state   = r_state;
        emit      = 1'b0;
        o_req_pop = 1'b0;
        do_ins    = 1'b0;
        do_pop    = 1'b0;
        n_rk      = teq_pkg::RK_ACK;
        n_okind   = i_req.kind;
        n_otag    = '0;
        n_oval    = '0;
        n_ok      = 1'b1;
        n_olast   = 1'b1;
        case (r_state)
            teq_pkg::ST_IDLE: begin
                if (i_req_valid) begin
                    if (i_req.op == teq_pkg::OP_TICK) begin
                        n_state = teq_pkg::ST_TICK;
                    end else if (out_free) begin
                        emit      = 1'b1;
                        o_req_pop = 1'b1;
                        case (i_req.op)
                            teq_pkg::OP_SCHED: begin
                                n_rk   = teq_pkg::RK_ACK;
                                n_ok   = !full;
                                do_ins = !full;
                            end
                            teq_pkg::OP_QCOUNT: begin
                                n_rk   = teq_pkg::RK_COUNT;
                                n_oval = k_in ? 32'(r_count[kidx]) : 32'd0;
                            end
                            default: begin
                                n_rk = teq_pkg::RK_AGE;
                                n_ok = k_in && r_mark[kidx];
                                if (k_in && r_mark[kidx] && i_req.now >= r_last[kidx]) begin
                                    n_oval = i_req.now - r_last[kidx];
                                end
                            end
                        endcase
                    end
                end
            end
            teq_pkg::ST_TICK: begin
                if (!due_now) begin
                    // nothing due at all
                    n_state   = teq_pkg::ST_IDLE;
                    o_req_pop = 1'b1;
                end else if (out_free) begin
                    emit    = 1'b1;
                    do_pop  = 1'b1;
                    n_rk    = teq_pkg::RK_FIRED;
                    n_okind = r_kind[0];
                    n_otag  = r_tag[0];
                    n_olast = (r_npop == PW'(teq_pkg::MAX_POP - 1)) || (r_fill < FW'(2))
                              || (r_due[1] > i_req.now);
                    if (n_olast) begin
                        n_state   = teq_pkg::ST_IDLE;
                        o_req_pop = 1'b1;
                    end
                end
            end
            default: n_state = teq_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= teq_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
            r_fill      <= '0;
            r_npop      <= '0;
            r_mark      <= '0;
            for (int k = 0; k < NUM_KINDS; k++) begin
                r_count[k] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == teq_pkg::ST_IDLE) begin
                r_npop <= '0;
            end else if (do_pop) begin
                r_npop <= r_npop + 1'b1;
            end
            if (do_ins) begin
                r_fill <= r_fill + 1'b1;
                if (k_in && r_count[kidx] < teq_pkg::CNT_W'(teq_pkg::COUNT_MAX)) begin
                    r_count[kidx] <= r_count[kidx] + 1'b1;
                end
            end
            if (do_pop) begin
                r_fill <= r_fill - 1'b1;
                if (f_in) begin
                    r_mark[fidx] <= 1'b1;
                    if (r_count[fidx] != '0) begin
                        r_count[fidx] <= r_count[fidx] - 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_pop && f_in) begin
            r_last[fidx] <= i_req.now;
        end
        if (emit) begin
            r_rk    <= n_rk;
            r_okind <= n_okind;
            r_otag  <= n_otag;
            r_oval  <= n_oval;
            r_ok    <= n_ok;
            r_olast <= n_olast;
        end
    end

    genvar g;
    generate
        for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
            always_ff @(posedge i_clk) begin
                if (do_ins) begin
                    if ((g > 0) && gt[(g > 0) ? g - 1 : 0]) begin
                        r_due[g]  <= r_due[(g > 0) ? g - 1 : 0];
                        r_kind[g] <= r_kind[(g > 0) ? g - 1 : 0];
                        r_tag[g]  <= r_tag[(g > 0) ? g - 1 : 0];
                    end else if (gt[g] || (FW'(g) == r_fill)) begin
                        r_due[g]  <= i_req.due;
                        r_kind[g] <= i_req.kind;
                        r_tag[g]  <= i_req.tag;
                    end
                end else if (do_pop && (g < QUEUE_DEPTH - 1)) begin
                    r_due[g]  <= r_due[(g < QUEUE_DEPTH - 1) ? g + 1 : g];
                    r_kind[g] <= r_kind[(g < QUEUE_DEPTH - 1) ? g + 1 : g];
                    r_tag[g]  <= r_tag[(g < QUEUE_DEPTH - 1) ? g + 1 : g];
                end
            end
        end
    endgenerate

    assign o_out_valid   = r_out_valid;
    assign o_reply_kind  = r_rk;
    assign o_out_kind    = r_okind;
    assign o_out_tag     = r_otag;
    assign o_reply_value = r_oval;
    assign o_ok_flag     = r_ok;
    assign o_last_flag   = r_olast;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FW'(QUEUE_DEPTH))
        else $error("queue fill beyond depth");

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |-> out_free)
        else $error("result overwrites a waiting result");

    a_tick_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == teq_pkg::ST_TICK) |-> (i_req_valid && i_req.op == teq_pkg::OP_TICK))
        else $error("tick state without tick request");

    a_no_both: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(do_ins && do_pop))
        else $error("insert and pop together");

    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_out_valid)
        else $error("output valid after reset");

endmodule

[rtl/timed_event_queue.sv]
// timed event queue
// input channel: i_in_valid / o_in_stall, a request is taken when valid is
// high and stall is low; fields i_cmd, i_event_kind, i_time_value,
// i_now_time, i_label_tag. unknown commands are taken and dropped.
// output channel: o_out_valid / i_out_stall with one registered result;
// o_last_flag marks the final result of a request.
// a front stage computes the due time and classifies requests by command
// into a two-entry queue; the back part owns the sorted queue cells and the
// per-kind counters and runs one operation at a time.
// schedule and query: via the front queue entry and then the result register.
// tick: the back part enters its tick state, then fires one event per cycle
// from the head cell unless the receiver stalls, up to 32 events; nothing due
// means no result. while the receiver stalls the result register holds and
// the back part waits; the front keeps taking requests until its queue is full.
// reset (synchronous, active low) empties the queue and clears counts and
// fire marks at once; no clearing pass.
module timed_event_queue #(
    parameter int QUEUE_DEPTH = teq_pkg::QUEUE_DEPTH_DEF,
    parameter int NUM_KINDS   = teq_pkg::NUM_KINDS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_cmd,
    input  logic [3:0]  i_event_kind,
    input  logic [31:0] i_time_value,
    input  logic [31:0] i_now_time,
    input  logic [15:0] i_label_tag,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_reply_kind,
    output logic [3:0]  o_out_kind,
    output logic [15:0] o_out_tag,
    output logic [31:0] o_reply_value,
    output logic        o_ok_flag,
    output logic        o_last_flag
);

    teq_pkg::t_req req;
    logic          req_valid;
    logic          req_pop;

    teq_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_cmd        (i_cmd),
        .i_event_kind (i_event_kind),
        .i_time_value (i_time_value),
        .i_now_time   (i_now_time),
        .i_label_tag  (i_label_tag),
        .o_req        (req),
        .o_req_valid  (req_valid),
        .i_req_pop    (req_pop)
    );

    teq_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .NUM_KINDS   (NUM_KINDS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req         (req),
        .i_req_valid   (req_valid),
        .o_req_pop     (req_pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_reply_kind  (o_reply_kind),
        .o_out_kind    (o_out_kind),
        .o_out_tag     (o_out_tag),
        .o_reply_value (o_reply_value),
        .o_ok_flag     (o_ok_flag),
        .o_last_flag   (o_last_flag)
    );

endmodule

[tb/tb_timed_event_queue.sv]
`timescale 1ns / 1ps

module tb_timed_event_queue;

    localparam int DEPTH = 32;
    localparam int KINDS = 16;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic [1:0]  rkind;
        logic [3:0]  kind;
        logic [15:0] tag;
        logic [31:0] value;
        logic        ok;
        logic        last;
    } t_reply;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [2:0]  i_cmd;
    logic [3:0]  i_event_kind;
    logic [31:0] i_time_value;
    logic [31:0] i_now_time;
    logic [15:0] i_label_tag;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [1:0]  o_reply_kind;
    logic [3:0]  o_out_kind;
    logic [15:0] o_out_tag;
    logic [31:0] o_reply_value;
    logic        o_ok_flag;
    logic        o_last_flag;

    timed_event_queue uut (.*);

    // predictor state
    logic [31:0] q_due [DEPTH];
    logic [3:0]  q_kind [DEPTH];
    logic [15:0] q_tag [DEPTH];
    int          q_fill;
    logic [5:0]  kind_count [KINDS];
    logic [31:0] kind_last_fire [KINDS];
    logic        kind_fired [KINDS];

    t_reply expected_replies[$];
    int     errors;
    int     n_requests;
    int     n_replies;
    int     n_fired;
    int     n_full;
    int     idle_cycles;
    bit     rx_hold;
    bit     no_idle;
    logic [31:0] sim_now;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic void add_reply(logic [1:0] rk, logic [3:0] kd, logic [15:0] tg,
                                      logic [31:0] val, logic ok);
        t_reply r;
        r.rkind = rk;
        r.kind = kd;
        r.tag = tg;
        r.value = val;
        r.ok = ok;
        r.last = 1'b0;
        expected_replies = {expected_replies, r};
    endfunction

    function automatic void enqueue_event(logic [3:0] kd, logic [31:0] due, logic [15:0] tg);
        int pos;
        if (q_fill >= DEPTH) begin
            add_reply(teq_pkg::RK_ACK, kd, '0, '0, 1'b0);
            n_full++;
            return;
        end
        pos = q_fill;
        while (pos > 0 && q_due[pos-1] > due) pos--;
        for (int i = q_fill; i > pos; i--) begin
            q_due[i] = q_due[i-1];
            q_kind[i] = q_kind[i-1];
            q_tag[i] = q_tag[i-1];
        end
        q_due[pos] = due;
        q_kind[pos] = kd;
        q_tag[pos] = tg;
        q_fill++;
        if (kind_count[kd] < teq_pkg::COUNT_MAX) kind_count[kd]++;
        add_reply(teq_pkg::RK_ACK, kd, '0, '0, 1'b1);
    endfunction

    // works out the replies one request causes
    function automatic void predict_replies(logic [2:0] cmd, logic [3:0] kd, logic [31:0] tval,
                                            logic [31:0] now, logic [15:0] tg);
        int n_prior;
        int popped;
        logic [32:0] sum;
        n_prior = expected_replies.size();
        case (cmd)
            teq_pkg::CMD_DELAY: begin
                sum = {1'b0, now} + {1'b0, tval};
                enqueue_event(kd, sum[32] ? 32'hFFFF_FFFF : sum[31:0], tg);
            end
            teq_pkg::CMD_ABS: enqueue_event(kd, tval, tg);
            teq_pkg::CMD_TICK: begin
                popped = 0;
                while (q_fill > 0 && popped < teq_pkg::MAX_POP && q_due[0] <= now) begin
                    add_reply(teq_pkg::RK_FIRED, q_kind[0], q_tag[0], '0, 1'b1);
                    if (kind_count[q_kind[0]] > 0) kind_count[q_kind[0]]--;
                    kind_last_fire[q_kind[0]] = now;
                    kind_fired[q_kind[0]] = 1'b1;
                    for (int i = 1; i < q_fill; i++) begin
                        q_due[i-1] = q_due[i];
                        q_kind[i-1] = q_kind[i];
                        q_tag[i-1] = q_tag[i];
                    end
                    q_fill--;
                    popped++;
                    n_fired++;
                end
            end
            teq_pkg::CMD_QCOUNT:
                add_reply(teq_pkg::RK_COUNT, kd, '0, 32'(kind_count[kd]), 1'b1);
            teq_pkg::CMD_QAGE: begin
                if (kind_fired[kd])
                    add_reply(teq_pkg::RK_AGE, kd, '0,
                              (now >= kind_last_fire[kd]) ? now - kind_last_fire[kd] : '0,
                              1'b1);
                else
                    add_reply(teq_pkg::RK_AGE, kd, '0, '0, 1'b0);
            end
            default: ;
        endcase
        if (expected_replies.size() > n_prior)
            expected_replies[expected_replies.size()-1].last = 1'b1;
    endfunction

    // valid stays high into the next request; idle gaps and callers drop it
    task automatic send_request(logic [2:0] cmd, logic [3:0] kd, logic [31:0] tval,
                                logic [31:0] now, logic [15:0] tg);
        while (!no_idle && $urandom_range(99) < 16) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_cmd <= cmd;
        i_event_kind <= kd;
        i_time_value <= tval;
        i_now_time <= now;
        i_label_tag <= tg;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict_replies(cmd, kd, tval, now, tg);
        n_requests++;
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (expected_replies.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // receiver stall pattern
    always @(posedge i_clk) begin
        if (!i_rst_n) i_out_stall <= 1'b0;
        else i_out_stall <= rx_hold || (!no_idle && $urandom_range(99) < 16);
    end

    // reply checker
    always @(posedge i_clk) begin
        t_reply e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            n_replies++;
            if (expected_replies.size() == 0) begin
                $error("unexpected reply kind=%0d out_kind=%0d", o_reply_kind, o_out_kind);
                errors++;
            end else begin
                e = expected_replies.pop_front();
                if (o_reply_kind !== e.rkind) begin
                    $error("reply_kind expected %0d actual %0d", e.rkind, o_reply_kind);
                    errors++;
                end
                if (o_out_kind !== e.kind) begin
                    $error("out_kind expected %0d actual %0d", e.kind, o_out_kind);
                    errors++;
                end
                if (o_out_tag !== e.tag) begin
                    $error("out_tag expected %0h actual %0h", e.tag, o_out_tag);
                    errors++;
                end
                if (o_reply_value !== e.value) begin
                    $error("reply_value expected %0d actual %0d", e.value, o_reply_value);
                    errors++;
                end
                if (o_ok_flag !== e.ok) begin
                    $error("ok_flag expected %0b actual %0b", e.ok, o_ok_flag);
                    errors++;
                end
                if (o_last_flag !== e.last) begin
                    $error("last_flag expected %0b actual %0b", e.last, o_last_flag);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles with no handshake
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_timed_event_queue NOT OK");
            $finish;
        end
    end

    task automatic test_edges();
        send_request(teq_pkg::CMD_QCOUNT, 4'd0, '0, '0, '0);
        send_request(teq_pkg::CMD_QAGE, 4'd15, '0, 32'd100, '0);
        send_request(teq_pkg::CMD_TICK, 4'd0, '0, '0, '0);
        send_request(teq_pkg::CMD_ABS, 4'd0, 32'd0, 32'd0, 16'h0000);
        send_request(teq_pkg::CMD_DELAY, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
        send_request(teq_pkg::CMD_DELAY, 4'd3, 32'hFFFF_FFF0, 32'h20, 16'hA5A5);
        send_request(teq_pkg::CMD_ABS, 4'd3, 32'd10, 32'd0, 16'h5A5A);
        send_request(teq_pkg::CMD_ABS, 4'd7, 32'd10, 32'd0, 16'h1234);
        send_request(teq_pkg::CMD_QCOUNT, 4'd3, '0, '0, '0);
        send_request(3'd5, 4'd1, 32'd1, 32'd1, 16'd1);
        send_request(3'd7, 4'd2, '0, '0, '0);
        send_request(teq_pkg::CMD_TICK, 4'd0, '0, 32'd10, '0);
        send_request(teq_pkg::CMD_QAGE, 4'd3, '0, 32'd25, '0);
        send_request(teq_pkg::CMD_QAGE, 4'd3, '0, 32'd4, '0);
        send_request(teq_pkg::CMD_QCOUNT, 4'd3, '0, '0, '0);
        send_request(teq_pkg::CMD_TICK, 4'd0, '0, 32'hFFFF_FFFF, '0);
        wait_drained();
    endtask

    // fill to overflow and drain with one big tick
    task automatic test_full_queue();
        for (int i = 0; i < DEPTH + 2; i++)
            send_request(teq_pkg::CMD_ABS, 4'(i % 2), 32'(i % 5), 32'd0, 16'(i));
        send_request(teq_pkg::CMD_TICK, 4'd0, '0, 32'd100, '0);
        wait_drained();
    endtask

    // receiver holds off while requests keep coming
    task automatic test_backpressure();
        fork
            begin
                rx_hold = 1'b1;
                repeat (200) @(posedge i_clk);
                rx_hold = 1'b0;
            end
            begin
                for (int i = 0; i < 12; i++)
                    send_request(teq_pkg::CMD_QCOUNT, 4'($urandom_range(15)), '0, '0, '0);
                i_in_valid <= 1'b0;
            end
        join
        wait_drained();
    endtask

    task automatic test_random(int count);
        logic [2:0] cmd;
        int sel;
        for (int i = 0; i < count; i++) begin
            no_idle = (i >= count / 2 && i < count / 2 + 20);
            sel = $urandom_range(99);
            sim_now = sim_now + $urandom_range(20);
            if (sel < 40) cmd = teq_pkg::CMD_DELAY;
            else if (sel < 55) cmd = teq_pkg::CMD_ABS;
            else if (sel < 75) cmd = teq_pkg::CMD_TICK;
            else if (sel < 85) cmd = teq_pkg::CMD_QCOUNT;
            else if (sel < 95) cmd = teq_pkg::CMD_QAGE;
            else cmd = 3'($urandom_range(7, 5));
            send_request(cmd, 4'($urandom_range(15)),
                         ($urandom_range(9) == 0) ? $urandom : 32'($urandom_range(60)),
                         ($urandom_range(19) == 0) ? $urandom : sim_now,
                         16'($urandom));
        end
        no_idle = 1'b0;
        send_request(teq_pkg::CMD_TICK, 4'd0, '0, 32'hFFFF_FFFF, '0);
        wait_drained();
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_cmd = '0;
        i_event_kind = '0;
        i_time_value = '0;
        i_now_time = '0;
        i_label_tag = '0;
        i_out_stall = 1'b0;
        rx_hold = 1'b0;
        no_idle = 1'b0;
        errors = 0;
        n_requests = 0;
        n_replies = 0;
        n_fired = 0;
        n_full = 0;
        idle_cycles = 0;
        sim_now = 32'd50;
        q_fill = 0;
        for (int k = 0; k < KINDS; k++) begin
            kind_count[k] = '0;
            kind_last_fire[k] = '0;
            kind_fired[k] = 1'b0;
        end
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_edges();
        test_full_queue();
        test_backpressure();
        test_random(46);
        repeat (10) @(posedge i_clk);

        $display("covered edge commands, queue overflow, long receiver hold and random traffic");
        $display("requests sent %0d, replies checked %0d, events fired %0d, full rejects %0d",
                 n_requests, n_replies, n_fired, n_full);
        if (errors == 0 && expected_replies.size() == 0) begin
            $display("tb_timed_event_queue OK");
        end else begin
            $display("tb_timed_event_queue NOT OK");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/teq_pkg.sv
rtl/teq_front.sv
rtl/teq_back.sv
rtl/timed_event_queue.sv
tb/tb_timed_event_queue.sv
